// ----- hdl/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants for the Taylor sine/cosine pipeline
// Fixed-point constants, the lane record that moves between series stages,
// and the per-term divisor and reciprocal tables.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int SUM_W  = 34;
	localparam int TERM_W = 31;
	localparam int X2_W   = 32;

	localparam int SERIES_FRAC  = 28;
	localparam int RECIP_2PI_SH = 40;
	localparam int TERM_DIV_SH  = 34;

	localparam logic        [26:0] PI_Q24      = 27'd52707179;
	localparam logic        [26:0] TWO_PI_Q24  = 27'd105414357;
	localparam logic signed [32:0] HALF_PI_Q24 = 33'sd26353589;
	localparam logic        [13:0] RECIP_2PI   = 14'd10430;

	localparam logic signed [SUM_W+1:0] ONE_Q30 = (SUM_W+2)'(64'sd1073741824);

	typedef struct packed {
		logic signed [SUM_W-1:0]  acc;
		logic        [TERM_W-1:0] tmag;
		logic        [X2_W-1:0]   x2;
		logic                     xneg;
	} lane_t;

	function automatic logic [31:0] term_recip(input int n);
		logic [31:0] r;
		case (n)
			1:       r = 32'd2863311530;
			2:       r = 32'd858993459;
			3:       r = 32'd409044504;
			4:       r = 32'd238609294;
			5:       r = 32'd156180628;
			6:       r = 32'd110127366;
			7:       r = 32'd81808900;
			8:       r = 32'd63161283;
			9:       r = 32'd50233535;
			10:      r = 32'd40904450;
			11:      r = 32'd33952310;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] term_div(input int n);
		return 9'((2 * n) * (2 * n + 1));
	endfunction

	function automatic logic signed [SUM_W-1:0] term_add(
		input logic signed [SUM_W-1:0]  acc,
		input logic        [TERM_W-1:0] tmag,
		input logic                     sub
	);
		logic signed [SUM_W-1:0] t;
		t = $signed({{(SUM_W - TERM_W){1'b0}}, tmag});
		return sub ? (acc - t) : (acc + t);
	endfunction

endpackage

// ----- hdl/taylor_sine_cosine.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine: pipelined Taylor-series sine and cosine
// Takes a Q8.24 angle and a sine/cosine select; returns Q2.30, saturated.
// ----------------------------------------------------------------------------
// One item enters per clock and one result leaves per clock while the
// output is not stalled. The pipeline has five stages of range reduction
// (cosine offset, reciprocal multiply by 1/(2*pi), remainder, fold into
// [-pi, pi], squaring), three stages per series term (term times x^2,
// reciprocal multiply by 1/((2n)(2n+1)), correction), and the saturating
// output register. Every stage holds only while the one after it is full
// and stalled, so bubbles are squeezed out and a stall loses nothing.
// ----------------------------------------------------------------------------
module taylor_sine_cosine #(
	parameter int NUM_TERMS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               kind,
	input  logic signed [31:0] angle,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] value
);

	tss_pkg::lane_t         lane_w  [NUM_TERMS];
	logic [NUM_TERMS-1:0]   valid_w;
	logic [NUM_TERMS-1:0]   stall_w;

	tss_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (req_valid),
		.up_stall (req_stall),
		.kind     (kind),
		.angle    (angle),
		.dn_valid (valid_w[0]),
		.dn_stall (stall_w[0]),
		.lane     (lane_w[0])
	);

	for (genvar i = 1; i < NUM_TERMS; i++) begin : g_term
		tss_term #(
			.TERM_IDX (i)
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_w[i-1]),
			.up_stall (stall_w[i-1]),
			.up_lane  (lane_w[i-1]),
			.dn_valid (valid_w[i]),
			.dn_stall (stall_w[i]),
			.dn_lane  (lane_w[i])
		);
	end

	tss_out #(
		.LAST_IDX (NUM_TERMS - 1)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_w[NUM_TERMS-1]),
		.up_stall (stall_w[NUM_TERMS-1]),
		.up_lane  (lane_w[NUM_TERMS-1]),
		.dn_valid (rsp_valid),
		.dn_stall (rsp_stall),
		.value    (value)
	);

endmodule

// ----- hdl/tss_reduce.sv -----
// ----------------------------------------------------------------------------
// tss_reduce: angle preparation and range reduction
// Forms pi/2 - angle for cosine, takes a truncating remainder modulo 2*pi by
// reciprocal multiply, folds into [-pi, pi], and squares the Q.28 argument.
// ----------------------------------------------------------------------------
module tss_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_stall,
	input  logic                kind,
	input  logic signed [31:0]  angle,
	output logic                dn_valid,
	input  logic                dn_stall,
	output tss_pkg::lane_t      lane
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        st1, st2, st3, st4, st5;

	logic [31:0] mag_s1;
	logic        neg_s1;
	logic [45:0] qm_s2;
	logic [31:0] mag_s2;
	logic        neg_s2;
	logic [26:0] rem_s3;
	logic        neg_s3;
	logic [29:0] xmag_s4;
	logic        xneg_s4;
	tss_pkg::lane_t lane_s5;

	logic signed [32:0] a_c;
	logic        [32:0] amag_c;
	logic        [5:0]  q_c;
	logic        [32:0] qd_c;
	logic        [32:0] rem_c;
	logic        [32:0] remf_c;
	logic        [26:0] fmag_c;
	logic               fneg_c;
	logic        [59:0] sq_c;

	assign st5      = v_s5 & dn_stall;
	assign st4      = v_s4 & st5;
	assign st3      = v_s3 & st4;
	assign st2      = v_s2 & st3;
	assign st1      = v_s1 & st2;
	assign up_stall = st1;
	assign dn_valid = v_s5;
	assign lane     = lane_s5;

	always_comb begin
		if (kind) begin
			a_c = tss_pkg::HALF_PI_Q24 - 33'(angle);
		end else begin
			a_c = 33'(angle);
		end
		amag_c = a_c[32] ? 33'(-a_c) : 33'(a_c);
	end

	always_comb begin
		q_c    = qm_s2[45:tss_pkg::RECIP_2PI_SH];
		qd_c   = 33'(q_c) * 33'(tss_pkg::TWO_PI_Q24);
		rem_c  = 33'(mag_s2) - qd_c;
		remf_c = (rem_c >= 33'(tss_pkg::TWO_PI_Q24)) ?
			(rem_c - 33'(tss_pkg::TWO_PI_Q24)) : rem_c;
	end

	always_comb begin
		if (rem_s3 > tss_pkg::PI_Q24) begin
			fmag_c = tss_pkg::TWO_PI_Q24 - rem_s3;
			fneg_c = ~neg_s3;
		end else begin
			fmag_c = rem_s3;
			fneg_c = neg_s3;
		end
	end

	assign sq_c = 60'(xmag_s4) * 60'(xmag_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= up_valid;
			if (!st2) v_s2 <= v_s1;
			if (!st3) v_s3 <= v_s2;
			if (!st4) v_s4 <= v_s3;
			if (!st5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (!st1) begin
			mag_s1 <= amag_c[31:0];
			neg_s1 <= a_c[32];
		end
		if (!st2) begin
			qm_s2  <= 46'(mag_s1) * 46'(tss_pkg::RECIP_2PI);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
		if (!st3) begin
			rem_s3 <= remf_c[26:0];
			neg_s3 <= neg_s2;
		end
		if (!st4) begin
			xmag_s4 <= {fmag_c[25:0], 4'b0000};
			xneg_s4 <= fneg_c;
		end
		if (!st5) begin
			lane_s5.acc  <= '0;
			lane_s5.tmag <= 31'(xmag_s4);
			lane_s5.x2   <= sq_c[59:tss_pkg::SERIES_FRAC];
			lane_s5.xneg <= xneg_s4;
		end
	end

endmodule

// ----- hdl/tss_term.sv -----
// ----------------------------------------------------------------------------
// tss_term: one Taylor term of the sine series
// Adds the incoming term into the running sum, then forms the next term as
// term * x^2 / ((2n)(2n+1) * 2^28) with a reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module tss_term #(
	parameter int TERM_IDX = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_stall,
	input  tss_pkg::lane_t up_lane,
	output logic           dn_valid,
	input  logic           dn_stall,
	output tss_pkg::lane_t dn_lane
);

	localparam logic [31:0] RECIP   = tss_pkg::term_recip(TERM_IDX);
	localparam logic [8:0]  DIVISOR = tss_pkg::term_div(TERM_IDX);
	localparam logic        SUB     = ((TERM_IDX - 1) % 2) == 1;

	logic v_s1, v_s2, v_s3;
	logic st1, st2, st3;

	logic signed [tss_pkg::SUM_W-1:0] acc_s1, acc_s2;
	logic        [61:0]               prod_s1;
	logic        [tss_pkg::X2_W-1:0]  x2_s1, x2_s2;
	logic                             xneg_s1, xneg_s2;
	logic        [33:0]               y_s2;
	logic        [65:0]               qm_s2;
	tss_pkg::lane_t                   lane_s3;

	logic [31:0] qe_c;
	logic [40:0] qd_c;
	logic [40:0] rem_c;
	logic [31:0] q_c;

	assign st3      = v_s3 & dn_stall;
	assign st2      = v_s2 & st3;
	assign st1      = v_s1 & st2;
	assign up_stall = st1;
	assign dn_valid = v_s3;
	assign dn_lane  = lane_s3;

	always_comb begin
		qe_c  = qm_s2[65:tss_pkg::TERM_DIV_SH];
		qd_c  = 41'(qe_c) * 41'(DIVISOR);
		rem_c = 41'(y_s2) - qd_c;
		q_c   = (rem_c >= 41'(DIVISOR)) ? (qe_c + 32'd1) : qe_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= up_valid;
			if (!st2) v_s2 <= v_s1;
			if (!st3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!st1) begin
			acc_s1  <= tss_pkg::term_add(up_lane.acc, up_lane.tmag, up_lane.xneg ^ SUB);
			prod_s1 <= 62'(up_lane.tmag) * 62'(up_lane.x2);
			x2_s1   <= up_lane.x2;
			xneg_s1 <= up_lane.xneg;
		end
		if (!st2) begin
			y_s2    <= prod_s1[61:tss_pkg::SERIES_FRAC];
			qm_s2   <= 66'(prod_s1[61:tss_pkg::SERIES_FRAC]) * 66'(RECIP);
			acc_s2  <= acc_s1;
			x2_s2   <= x2_s1;
			xneg_s2 <= xneg_s1;
		end
		if (!st3) begin
			lane_s3.acc  <= acc_s2;
			lane_s3.tmag <= q_c[tss_pkg::TERM_W-1:0];
			lane_s3.x2   <= x2_s2;
			lane_s3.xneg <= xneg_s2;
		end
	end

endmodule

// ----- hdl/tss_out.sv -----
// ----------------------------------------------------------------------------
// tss_out: final accumulation and output register
// Adds the last term, scales the Q.28 sum to Q2.30 and saturates to +/-1.0.
// ----------------------------------------------------------------------------
module tss_out #(
	parameter int LAST_IDX = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  tss_pkg::lane_t     up_lane,
	output logic               dn_valid,
	input  logic               dn_stall,
	output logic signed [31:0] value
);

	localparam logic SUB = (LAST_IDX % 2) == 1;

	logic               valid_q;
	logic signed [31:0] value_q;

	logic signed [tss_pkg::SUM_W-1:0] acc_c;
	logic signed [tss_pkg::SUM_W+1:0] v4_c;
	logic signed [tss_pkg::SUM_W+1:0] sat_c;

	assign up_stall = valid_q & dn_stall;
	assign dn_valid = valid_q;
	assign value    = value_q;

	always_comb begin
		acc_c = tss_pkg::term_add(up_lane.acc, up_lane.tmag, up_lane.xneg ^ SUB);
		v4_c  = {acc_c, 2'b00};
		if (v4_c > tss_pkg::ONE_Q30) begin
			sat_c = tss_pkg::ONE_Q30;
		end else if (v4_c < -tss_pkg::ONE_Q30) begin
			sat_c = -tss_pkg::ONE_Q30;
		end else begin
			sat_c = v4_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall) begin
			value_q <= 32'(sat_c);
		end
	end

endmodule

// ----- verif/taylor_sine_cosine_checker.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine_checker: result predictor and comparator
// Watches both channels of the Taylor sine/cosine pipeline, computes the
// expected Q2.30 value for every accepted angle and compares it, in order,
// with every accepted result.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_checker #(
	parameter int NUM_TERMS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic               kind,
	input  logic signed [31:0] angle,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [31:0] value,
	output int                 mismatches,
	output int                 outstanding
);

	localparam longint ANG_PI      = 64'sd52707179;
	localparam longint ANG_TWO_PI  = 64'sd105414357;
	localparam longint ANG_HALF_PI = 64'sd26353589;
	localparam longint UNIT_Q30    = 64'sd1073741824;
	localparam int     SERIES_FRAC = 28;
	localparam int     REPORT_MAX  = 10;

	logic signed [31:0] pending_values[$];
	int                 miscount = 0;

	function automatic logic signed [31:0] taylor_value(
		input logic               is_cos,
		input logic signed [31:0] ang
	);
		longint theta;
		longint turns;
		longint folded;
		longint x;
		longint x_sq;
		longint term;
		longint series;
		longint scaled;
		theta = longint'(ang);
		if (is_cos)
			theta = ANG_HALF_PI - theta;
		turns  = theta / ANG_TWO_PI;
		folded = theta - turns * ANG_TWO_PI;
		if (folded > ANG_PI)
			folded = folded - ANG_TWO_PI;
		if (folded < -ANG_PI)
			folded = folded + ANG_TWO_PI;
		x      = folded * 16;
		x_sq   = (x * x) >>> SERIES_FRAC;
		term   = x;
		series = x;
		for (int n = 1; n < NUM_TERMS; n++) begin
			term = (term * x_sq) / (longint'((2 * n) * (2 * n + 1)) <<< SERIES_FRAC);
			if (n % 2 == 1)
				series = series - term;
			else
				series = series + term;
		end
		scaled = series * 4;
		if (scaled > UNIT_Q30)
			scaled = UNIT_Q30;
		if (scaled < -UNIT_Q30)
			scaled = -UNIT_Q30;
		return scaled[31:0];
	endfunction

	always @(posedge clk) begin
		logic signed [31:0] want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				pending_values.push_back(taylor_value(kind, angle));
			if (rsp_valid && !rsp_stall) begin
				if (pending_values.size() == 0) begin
					miscount++;
					if (miscount <= REPORT_MAX)
						$display("%0t: result %0d (0x%08h) with no transfer pending",
							$time, value, value);
				end else begin
					want = pending_values.pop_front();
					if (value !== want) begin
						miscount++;
						if (miscount <= REPORT_MAX)
							$display("%0t: value expected %0d (0x%08h) got %0d (0x%08h)",
								$time, want, want, value, value);
					end
				end
			end
		end
		mismatches  <= miscount;
		outstanding <= pending_values.size();
	end

endmodule

// ----- verif/tb_taylor_sine_cosine.sv -----
// ----------------------------------------------------------------------------
// tb_taylor_sine_cosine: testbench for the Taylor sine/cosine pipeline
// Sends directed boundary angles and then random angles of both kinds,
// with random gaps on the sender and random stalls on the receiver, a long
// receiver hold-off that backs the pipeline up, and checks every result.
// ----------------------------------------------------------------------------
module tb_taylor_sine_cosine;

	localparam int TERMS       = 8;
	localparam int ANGLE_PI    = 52707179;
	localparam int ANGLE_2PI   = 105414357;
	localparam int ANGLE_HPI   = 26353589;
	localparam int PHASE_ITEMS = 510;
	localparam int HOLD_OFF    = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN       = 40;

	localparam logic KIND_SINE   = 1'b0;
	localparam logic KIND_COSINE = 1'b1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               kind;
	logic signed [31:0] angle;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [31:0] value;

	int mismatches;
	int outstanding;
	int phase = 0;
	int send_idle_pct = 20;
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	taylor_sine_cosine #(
		.NUM_TERMS(TERMS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind     (kind),
		.angle    (angle),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.value    (value)
	);

	taylor_sine_cosine_checker #(
		.NUM_TERMS(TERMS)
	) sincos_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.angle      (angle),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.value      (value),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	task automatic send_angle(input logic k, input logic signed [31:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		angle     <= a;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_angle();
		int k;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(8 * ANGLE_PI) - 4 * ANGLE_PI;
			2: begin
				k = int'($urandom_range(160)) - 80;
				return k * ANGLE_HPI + int'($urandom_range(8)) - 4;
			end
			default: begin
				if ($urandom_range(1))
					return 32'sh7FFFFFFF - $urandom_range(255);
				return 32'sh80000000 + $urandom_range(255);
			end
		endcase
	endfunction

	// receiver: random stalls in phases 0 and 1, one long hold-off when phase 2 opens
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && phase == 2) begin
				held = 1;
				hold = HOLD_OFF;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < (phase == 0 ? 51 : (phase == 1 ? 20 : 0)));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** taylor_sine_cosine: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		kind      <= KIND_SINE;
		angle     <= 32'sd0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		send_angle(KIND_SINE, 32'sd0);
		send_angle(KIND_COSINE, 32'sd0);
		send_angle(KIND_SINE, 32'sd1);
		send_angle(KIND_SINE, -32'sd1);
		send_angle(KIND_SINE, ANGLE_HPI);
		send_angle(KIND_SINE, -ANGLE_HPI);
		send_angle(KIND_COSINE, ANGLE_HPI);
		send_angle(KIND_COSINE, -ANGLE_HPI);
		send_angle(KIND_SINE, ANGLE_PI);
		send_angle(KIND_SINE, ANGLE_PI + 1);
		send_angle(KIND_SINE, -ANGLE_PI);
		send_angle(KIND_SINE, -ANGLE_PI - 1);
		send_angle(KIND_COSINE, ANGLE_PI + ANGLE_HPI + 1);
		send_angle(KIND_SINE, ANGLE_2PI);
		send_angle(KIND_SINE, ANGLE_2PI - 1);
		send_angle(KIND_SINE, -ANGLE_2PI);
		send_angle(KIND_SINE, -ANGLE_2PI - ANGLE_PI - 1);
		send_angle(KIND_SINE, 32'sh7FFFFFFF);
		send_angle(KIND_SINE, 32'sh80000000);
		send_angle(KIND_COSINE, 32'sh7FFFFFFF);
		send_angle(KIND_COSINE, 32'sh80000000);
		send_angle(KIND_COSINE, 32'sh80000001);
		send_angle(KIND_SINE, 32'sh55555555);
		send_angle(KIND_COSINE, 32'shAAAAAAAA);

		for (int i = 0; i < PHASE_ITEMS; i++)
			send_angle(1'($urandom_range(1)), pick_angle());

		send_idle_pct = 51;
		phase <= 1;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_angle(1'($urandom_range(1)), pick_angle());

		send_idle_pct = 0;
		phase <= 2;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_angle(1'($urandom_range(1)), pick_angle());
		req_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN)
			@(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** taylor_sine_cosine: PASSED **");
		else
			$display("** taylor_sine_cosine: FAILED **");
		$finish;
	end

endmodule
